@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as disable
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rsdt_pkg.sv @@
// ---------------------------------------------------------------------------
// rsdt_pkg
// shared types and constants of the endpoint table classifier
// ---------------------------------------------------------------------------
package rsdt_pkg;

    localparam int ENTRIES     = 16;
    localparam int POS_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] ICMP_PROTO = 8'd1;
    localparam int         TYPE_LIMIT = 32;

    // commands
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP  = 2'd2;
    localparam logic [1:0] CMD_SETMASK = 2'd3;

    // result status codes
    localparam logic [2:0] RES_DONE      = 3'd0;
    localparam logic [2:0] RES_DELIVERED = 3'd1;
    localparam logic [2:0] RES_FILTERED  = 3'd2;
    localparam logic [2:0] RES_NOMATCH   = 3'd3;
    localparam logic [2:0] RES_NOTSUP    = 3'd4;

    // broadcast key / entry payload
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] remote_addr;
        logic [31:0] local_addr;
        logic [7:0]  device;
        logic [7:0]  icmp_type;
        logic        icmp_header_ok;
        logic [31:0] block_mask;
    } key_t;

    // per-cell control
    typedef struct packed {
        logic ins;
        logic rem;
        logic setm;
        logic cmp;
        logic shift;
    } cell_ctl_t;

    // control into the row of cells
    typedef struct packed {
        cell_ctl_t  op;
        logic [3:0] slot;
    } chain_ctl_t;

endpackage

@@ sv/raw_socket_demux_table.sv @@
// ---------------------------------------------------------------------------
// raw_socket_demux_table
// wildcard receive endpoint table with slot-ordered packet classification
// ---------------------------------------------------------------------------
// usage
//   s_* carries commands: s_tuser is the command (insert, remove, lookup,
//   set icmp mask), s_tdata the slot, packet or entry fields and the mask
//   m_* carries results: m_tdata the slot, m_tuser the status, m_tlast
//   marks the final result beat of one command
// command flow
//   one command at a time; s_tready is high only while the block is idle
//   insert, remove and mask set: the result is loaded from the execute
//   state once the output register is free, then the block returns to idle
//   lookup: all cells compare in the execute state, then a scan as the hit
//   flags shift down the cell row, one slot per cycle while no matching
//   slot waits on a full output register
// reset
//   all entries become empty, no result is pending, the block is idle
// stall
//   the output register holds a result until taken; the scan waits at a
//   matching slot while the register is full, non-matching slots still
//   shift on
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module raw_socket_demux_table
    import rsdt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: slot[3:0], protocol[11:4], remote_addr[43:12], local_addr[75:44],
    //        device[83:76], icmp_type[91:84], icmp_header_ok[92],
    //        block_mask[124:93], zero pad[127:125]
    input  logic [127:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]   s_tuser,
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: result_slot[3:0], zero pad[7:4]
    output logic [7:0]   m_tdata,
    // tuser: status[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    // control states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       cmd_reg;
    logic [3:0]       slot_reg;
    key_t             key_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       out_slot_reg;
    logic [2:0]       out_status_reg;
    logic             out_last_reg;
    logic             out_load;
    logic [3:0]       ld_slot;
    logic [2:0]       ld_status;
    logic             ld_last;
    logic             out_free;

    chain_ctl_t       ctl;
    logic             head_hit;
    logic             head_filt;
    logic             tail_any;
    logic             mask_ok;
    logic             in_range;
    logic             accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign in_range = (int'(slot_reg) < ENTRIES);

    rsdt_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .key       (key_reg),
        .head_hit  (head_hit),
        .head_filt (head_filt),
        .tail_any  (tail_any),
        .mask_ok   (mask_ok)
    );

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        ctl.slot   = slot_reg;
        out_load   = 1'b0;
        ld_slot    = slot_reg;
        ld_status  = RES_DONE;
        ld_last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_LOOKUP)
                begin
                    // every cell compares against the held packet key
                    ctl.op.cmp = 1'b1;
                    pos_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (!in_range)
                        ld_status = RES_NOTSUP;
                    else
                    begin
                        unique case (cmd_reg)
                            CMD_INSERT:  ctl.op.ins = 1'b1;
                            CMD_REMOVE:  ctl.op.rem = 1'b1;
                            CMD_SETMASK:
                            begin
                                ctl.op.setm = mask_ok;
                                ld_status   = mask_ok ? RES_DONE : RES_NOTSUP;
                            end
                            default:     ld_status = RES_NOTSUP;
                        endcase
                    end
                end
            end
            S_DRAIN:
            begin
                priority if (cnt_reg == '0 && !head_hit && !tail_any)
                begin
                    // nothing matched at all
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_slot    = 4'd0;
                        ld_status  = RES_NOMATCH;
                        state_next = S_IDLE;
                    end
                end
                else if (head_hit)
                begin
                    if (out_free)
                    begin
                        out_load     = 1'b1;
                        ld_slot      = 4'(pos_reg);
                        ld_status    = head_filt ? RES_FILTERED : RES_DELIVERED;
                        ld_last      = !tail_any
                                    || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                        ctl.op.shift = 1'b1;
                        pos_next     = pos_reg + 1'b1;
                        cnt_next     = cnt_reg + 1'b1;
                        if (ld_last)
                            state_next = S_IDLE;
                    end
                end
                else
                begin
                    // skip a non-matching slot
                    ctl.op.shift = 1'b1;
                    pos_next     = pos_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg                <= s_tuser;
            slot_reg               <= s_tdata[3:0];
            key_reg.protocol       <= s_tdata[11:4];
            key_reg.remote_addr    <= s_tdata[43:12];
            key_reg.local_addr     <= s_tdata[75:44];
            key_reg.device         <= s_tdata[83:76];
            key_reg.icmp_type      <= s_tdata[91:84];
            key_reg.icmp_header_ok <= s_tdata[92];
            key_reg.block_mask     <= s_tdata[124:93];
        end
        if (out_load)
        begin
            out_slot_reg   <= ld_slot;
            out_status_reg <= ld_status;
            out_last_reg   <= ld_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_slot_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // checks
    `ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC,
        "accepted command did not start execution")
    `ASSERT_NEXT(a_last_idle, (state_reg == S_DRAIN) && out_load && ld_last,
        state_reg == S_IDLE, "scan continued after its final result")
    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(MAX_RESULTS),
        "result count exceeded its limit")

endmodule

@@ sv/rsdt_cell.sv @@
// ---------------------------------------------------------------------------
// rsdt_cell
// one table entry: stored endpoint, match logic and one stage of the hit chain
// ---------------------------------------------------------------------------
module rsdt_cell
    import rsdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      sel,
    input  key_t      key,
    input  logic      hit_in,
    input  logic      filt_in,
    output logic      hit,
    output logic      filt,
    output logic      mask_ok
);

    logic        valid_reg;
    logic [7:0]  proto_reg;
    logic [31:0] remote_reg;
    logic [31:0] local_reg;
    logic [7:0]  device_reg;
    logic [31:0] mask_reg;
    logic        hit_reg;
    logic        filt_reg;
    logic        match;
    logic        filtered;

    assign match = valid_reg && (proto_reg == key.protocol)
                && ((remote_reg == 32'd0) || (remote_reg == key.remote_addr))
                && ((local_reg == 32'd0) || (local_reg == key.local_addr))
                && ((device_reg == 8'd0) || (device_reg == key.device));

    // icmp only: short header or blocked type below the limit
    assign filtered = (key.protocol == ICMP_PROTO)
                   && (!key.icmp_header_ok
                       || ((key.icmp_type < 8'(TYPE_LIMIT)) && mask_reg[key.icmp_type[4:0]]));

    assign mask_ok = valid_reg && (proto_reg == ICMP_PROTO);
    assign hit     = hit_reg;
    assign filt    = filt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (sel && ctl.ins)
                valid_reg <= 1'b1;
            else if (sel && ctl.rem)
                valid_reg <= 1'b0;
            if (ctl.cmp)
                hit_reg <= match;
            else if (ctl.shift)
                hit_reg <= hit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && ctl.ins)
        begin
            proto_reg  <= key.protocol;
            remote_reg <= key.remote_addr;
            local_reg  <= key.local_addr;
            device_reg <= key.device;
            mask_reg   <= 32'd0;
        end
        else if (sel && ctl.setm)
            mask_reg <= key.block_mask;
        if (ctl.cmp)
            filt_reg <= filtered;
        else if (ctl.shift)
            filt_reg <= filt_in;
    end

endmodule

@@ sv/rsdt_chain.sv @@
// ---------------------------------------------------------------------------
// rsdt_chain
// row of entry cells; hit flags shift towards cell 0 during a scan
// ---------------------------------------------------------------------------
module rsdt_chain
    import rsdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_ctl_t ctl,
    input  key_t       key,
    output logic       head_hit,
    output logic       head_filt,
    output logic       tail_any,
    output logic       mask_ok
);

    logic [ENTRIES:0]   hit_ext;
    logic [ENTRIES:0]   filt_ext;
    logic [ENTRIES-1:0] ok_w;
    logic [ENTRIES-1:0] sel_w;

    assign hit_ext[ENTRIES]  = 1'b0;
    assign filt_ext[ENTRIES] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign sel_w[i] = (ENTRIES <= 16 || i < 16) && (ctl.slot == 4'(i));

        rsdt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl.op),
            .sel     (sel_w[i]),
            .key     (key),
            .hit_in  (hit_ext[i+1]),
            .filt_in (filt_ext[i+1]),
            .hit     (hit_ext[i]),
            .filt    (filt_ext[i]),
            .mask_ok (ok_w[i])
        );
    end

    assign head_hit  = hit_ext[0];
    assign head_filt = filt_ext[0];
    assign tail_any  = |hit_ext[ENTRIES:1];
    assign mask_ok   = |(ok_w & sel_w);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the endpoint table classifier: a queue-fed stream
// driver, a result monitor and a table predictor updated on each accepted
// command beat, run through phases of sender idling and receiver stalls
// ---------------------------------------------------------------------------

module testbench;
    import rsdt_pkg::*;

    // one command beat as the stimulus sees it
    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic [7:0]  protocol;
        logic [31:0] remote_addr;
        logic [31:0] local_addr;
        logic [7:0]  device;
        logic [7:0]  icmp_type;
        logic        icmp_header_ok;
        logic [31:0] block_mask;
        logic        drain;          // hold off until every result is back
    } table_cmd_t;

    // one result beat
    typedef struct packed {
        logic [3:0] slot;
        logic [2:0] status;
        logic       last;
    } table_result_t;

    localparam logic [31:0] ADDR_ONES = 32'hFFFF_FFFF;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = CMD_INSERT;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    table_cmd_t    pending_cmds[$];
    table_result_t expected_results[$];
    table_cmd_t    cmd_on_bus;
    int            cmds_queued;
    int            cmds_accepted;
    int            mismatches;
    int            send_idle_pct;
    int            recv_stall_pct;

    // predicted table contents, updated as command beats are accepted
    bit          tbl_valid    [ENTRIES];
    logic [7:0]  tbl_protocol [ENTRIES];
    logic [31:0] tbl_remote   [ENTRIES];
    logic [31:0] tbl_local    [ENTRIES];
    logic [7:0]  tbl_device   [ENTRIES];
    logic [31:0] tbl_mask     [ENTRIES];

    // table as the stimulus will have left it, used to aim lookups at entries
    bit          plan_valid    [ENTRIES];
    logic [7:0]  plan_protocol [ENTRIES];
    logic [31:0] plan_remote   [ENTRIES];
    logic [31:0] plan_local    [ENTRIES];
    logic [7:0]  plan_device   [ENTRIES];

    raw_socket_demux_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // predictor: table update and the result beats one command produces
    // -----------------------------------------------------------------------
    function automatic void classify_and_update(table_cmd_t c);
        int            hit_slots[$];
        table_result_t r;
        begin
            if (c.cmd == CMD_LOOKUP)
            begin
                for (int i = 0; i < ENTRIES && hit_slots.size() < MAX_RESULTS; i++)
                begin
                    if (tbl_valid[i] && tbl_protocol[i] == c.protocol
                        && (tbl_remote[i] == 0 || tbl_remote[i] == c.remote_addr)
                        && (tbl_local[i] == 0 || tbl_local[i] == c.local_addr)
                        && (tbl_device[i] == 0 || tbl_device[i] == c.device))
                        hit_slots.push_back(i);
                end
                if (hit_slots.size() == 0)
                begin
                    r.slot   = 4'd0;
                    r.status = RES_NOMATCH;
                    r.last   = 1'b1;
                    expected_results.push_back(r);
                end
                foreach (hit_slots[k])
                begin
                    r.slot   = 4'(hit_slots[k]);
                    r.status = RES_DELIVERED;
                    // icmp: short header or a blocked type below the limit
                    if (c.protocol == ICMP_PROTO
                        && (!c.icmp_header_ok
                            || (c.icmp_type < TYPE_LIMIT
                                && tbl_mask[hit_slots[k]][c.icmp_type[4:0]])))
                        r.status = RES_FILTERED;
                    r.last = (k == hit_slots.size() - 1);
                    expected_results.push_back(r);
                end
            end
            else
            begin
                r.slot   = c.slot;
                r.status = RES_DONE;
                r.last   = 1'b1;
                case (c.cmd)
                    CMD_INSERT:
                    begin
                        tbl_valid[c.slot]    = 1'b1;
                        tbl_protocol[c.slot] = c.protocol;
                        tbl_remote[c.slot]   = c.remote_addr;
                        tbl_local[c.slot]    = c.local_addr;
                        tbl_device[c.slot]   = c.device;
                        tbl_mask[c.slot]     = '0;
                    end
                    CMD_REMOVE:
                        tbl_valid[c.slot] = 1'b0;
                    default:
                    begin
                        // mask only applies to a live icmp entry
                        if (tbl_valid[c.slot] && tbl_protocol[c.slot] == ICMP_PROTO)
                            tbl_mask[c.slot] = c.block_mask;
                        else
                            r.status = RES_NOTSUP;
                    end
                endcase
                expected_results.push_back(r);
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------------
    function automatic void enqueue_cmd(table_cmd_t c);
        begin
            if (c.cmd == CMD_INSERT)
            begin
                plan_valid[c.slot]    = 1'b1;
                plan_protocol[c.slot] = c.protocol;
                plan_remote[c.slot]   = c.remote_addr;
                plan_local[c.slot]    = c.local_addr;
                plan_device[c.slot]   = c.device;
            end
            else if (c.cmd == CMD_REMOVE)
                plan_valid[c.slot] = 1'b0;
            pending_cmds.push_back(c);
            cmds_queued++;
        end
    endfunction

    function automatic table_cmd_t make_cmd(logic [1:0] op, int slot, logic [7:0] proto,
                                            logic [31:0] raddr, logic [31:0] laddr,
                                            logic [7:0] dev, logic [7:0] itype,
                                            logic hdr_ok, logic [31:0] mask);
        table_cmd_t c;
        begin
            c.cmd            = op;
            c.slot           = 4'(slot);
            c.protocol       = proto;
            c.remote_addr    = raddr;
            c.local_addr     = laddr;
            c.device         = dev;
            c.icmp_type      = itype;
            c.icmp_header_ok = hdr_ok;
            c.block_mask     = mask;
            c.drain          = 1'b0;
            return c;
        end
    endfunction

    // small pools so that entries overlap and lookups hit several slots
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'hC0A8_0001;
            2: return 32'h0A00_0002;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_protocol();
        case ($urandom_range(7))
            0, 1, 2, 3: return ICMP_PROTO;
            4: return 8'd6;
            5: return 8'd255;
            6: return 8'd0;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_device();
        case ($urandom_range(5))
            0, 1, 2: return 8'd0;
            3: return 8'd1;
            4: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // a live slot, optionally icmp only; -1 when there is none
    function automatic int find_planned_slot(bit icmp_only);
        int start;
        int idx;
        begin
            start = $urandom_range(ENTRIES - 1);
            for (int k = 0; k < ENTRIES; k++)
            begin
                idx = (start + k) % ENTRIES;
                if (plan_valid[idx] && (!icmp_only || plan_protocol[idx] == ICMP_PROTO))
                    return idx;
            end
            return -1;
        end
    endfunction

    function automatic table_cmd_t make_random_cmd();
        table_cmd_t c;
        int         sel;
        int         target;
        begin
            // unused fields carry noise too
            c = make_cmd(CMD_LOOKUP, $urandom_range(ENTRIES - 1), pick_protocol(), $urandom,
                         $urandom, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), $urandom);
            sel = $urandom_range(99);
            if (sel < 28)
            begin
                c.cmd         = CMD_INSERT;
                c.remote_addr = pick_addr();
                c.local_addr  = pick_addr();
                c.device      = pick_device();
            end
            else if (sel < 36)
                c.cmd = CMD_REMOVE;
            else if (sel < 50)
            begin
                c.cmd  = CMD_SETMASK;
                target = find_planned_slot(1'b1);
                if (target >= 0 && $urandom_range(3) != 0)
                    c.slot = 4'(target);
                case ($urandom_range(3))
                    0: c.block_mask = 32'hFFFF_FFFF;
                    1: c.block_mask = 32'h1 << $urandom_range(31);
                    2: c.block_mask = 32'h0;
                    default: ;
                endcase
            end
            else
            begin
                c.cmd  = CMD_LOOKUP;
                target = find_planned_slot(1'b0);
                // mostly packets aimed at a live entry, wildcards filled at random
                if (target >= 0 && $urandom_range(6) != 0)
                begin
                    c.protocol = plan_protocol[target];
                    if (plan_remote[target] != 0 && $urandom_range(9) != 0)
                        c.remote_addr = plan_remote[target];
                    else
                        c.remote_addr = pick_addr();
                    if (plan_local[target] != 0 && $urandom_range(9) != 0)
                        c.local_addr = plan_local[target];
                    else
                        c.local_addr = pick_addr();
                    if (plan_device[target] != 0 && $urandom_range(9) != 0)
                        c.device = plan_device[target];
                    else
                        c.device = pick_device();
                end
                if ($urandom_range(4) != 0)
                    c.icmp_type = 8'($urandom_range(TYPE_LIMIT - 1));
                c.icmp_header_ok = ($urandom_range(9) != 0);
            end
            return c;
        end
    endfunction

    // -----------------------------------------------------------------------
    // driver: command beats from the pending queue
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                classify_and_update(cmd_on_bus);
                cmds_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0
                    && !(pending_cmds[0].drain && expected_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_on_bus = pending_cmds.pop_front();
                    s_tvalid  <= 1'b1;
                    // tdata: slot, protocol, remote, local, device, type, hdr ok, mask
                    s_tdata   <= {3'b000, cmd_on_bus.block_mask, cmd_on_bus.icmp_header_ok,
                                  cmd_on_bus.icmp_type, cmd_on_bus.device,
                                  cmd_on_bus.local_addr, cmd_on_bus.remote_addr,
                                  cmd_on_bus.protocol, cmd_on_bus.slot};
                    s_tuser   <= cmd_on_bus.cmd;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // monitor: result beats against the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat slot %0d status %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if ({m_tdata, m_tuser, m_tlast} !== {4'b0000, want})
                    begin
                        $display("%0t: result mismatch expected slot %0d status %0d last %0b, got tdata %0h status %0d last %0b",
                                 $time, want.slot, want.status, want.last,
                                 m_tdata, m_tuser, m_tlast);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // -----------------------------------------------------------------------
    // stimulus and end of run
    // -----------------------------------------------------------------------
    initial
    begin
        table_cmd_t c;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // empty table: a lookup finds nothing
        enqueue_cmd(make_cmd(CMD_LOOKUP, 0, ICMP_PROTO, ADDR_ONES, ADDR_ONES, 8'd255,
                             8'd0, 1'b1, 32'h0));
        // fill every slot with icmp endpoints, the last two with exact fields
        for (int i = 0; i < ENTRIES - 2; i++)
            enqueue_cmd(make_cmd(CMD_INSERT, i, ICMP_PROTO, 32'h0, 32'h0, 8'd0,
                                 8'd0, 1'b1, 32'h0));
        enqueue_cmd(make_cmd(CMD_INSERT, ENTRIES - 2, ICMP_PROTO, ADDR_ONES, ADDR_ONES,
                             8'd0, 8'd0, 1'b1, 32'h0));
        enqueue_cmd(make_cmd(CMD_INSERT, ENTRIES - 1, ICMP_PROTO, 32'h0, 32'h0,
                             8'd255, 8'd0, 1'b1, 32'h0));
        // every entry matches: the longest result train
        enqueue_cmd(make_cmd(CMD_LOOKUP, 0, ICMP_PROTO, ADDR_ONES, ADDR_ONES, 8'd255,
                             8'd0, 1'b1, 32'h0));
        // overwrite with a non-icmp entry, whose mask cannot be set
        enqueue_cmd(make_cmd(CMD_INSERT, 13, 8'd255, 32'h0, 32'h0, 8'd0, 8'd0, 1'b0, 32'h0));
        enqueue_cmd(make_cmd(CMD_SETMASK, 13, 8'd0, 32'h0, 32'h0, 8'd0, 8'd0, 1'b0,
                             32'hFFFF_FFFF));
        enqueue_cmd(make_cmd(CMD_SETMASK, 0, 8'd0, 32'h0, 32'h0, 8'd0, 8'd0, 1'b0,
                             32'h8000_0001));
        enqueue_cmd(make_cmd(CMD_SETMASK, ENTRIES - 1, 8'd0, 32'h0, 32'h0, 8'd0, 8'd0, 1'b0,
                             32'hFFFF_FFFF));
        // highest blockable type, then a type past the limit with exact-field misses
        enqueue_cmd(make_cmd(CMD_LOOKUP, 0, ICMP_PROTO, ADDR_ONES, ADDR_ONES, 8'd255,
                             8'd31, 1'b1, 32'h0));
        enqueue_cmd(make_cmd(CMD_LOOKUP, 0, ICMP_PROTO, 32'h0, 32'h0, 8'd0,
                             8'd200, 1'b1, 32'h0));
        // short header filters every icmp hit
        enqueue_cmd(make_cmd(CMD_LOOKUP, 0, ICMP_PROTO, ADDR_ONES, ADDR_ONES, 8'd255,
                             8'd5, 1'b0, 32'h0));
        // non-icmp packet ignores the header flag
        enqueue_cmd(make_cmd(CMD_LOOKUP, 0, 8'd255, ADDR_ONES, 32'h0, 8'd7,
                             8'd0, 1'b0, 32'h0));

        while (pending_cmds.size() != 0)
            @(posedge clk);

        // random phases: none, sender idle, receiver stall, both lightly
        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int n = 0; n < 80; n++)
            begin
                c = make_random_cmd();
                c.drain = (n == 0) || ($urandom_range(49) == 0);
                enqueue_cmd(c);
            end
            while (pending_cmds.size() != 0)
                @(posedge clk);
        end

        while (cmds_accepted != cmds_queued || expected_results.size() != 0)
            @(posedge clk);
        // room for any stray beat to show up
        repeat (ENTRIES + 8) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
